FILE: sv/byte_budget_cache_evictor_defines.svh
// Assertion macros shared by the byte budget cache evictor RTL.
// Pulled in by the modules that carry concurrent assertions.
`ifndef BYTE_BUDGET_CACHE_EVICTOR_DEFINES_SVH
`define BYTE_BUDGET_CACHE_EVICTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbce assertion failed");

// antecedent implies consequent in the next cycle
`define BBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbce assertion failed");

`endif

FILE: sv/bbce_pkg.sv
// Package for the byte budget cache evictor: widths, status codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bbce_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 64;
  localparam int BYTES_W   = 32;
  localparam int STAMP_W   = 32;
  localparam int ENTRY_W   = KEY_W + BYTES_W + STAMP_W;

  localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd1000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       scan_start;
    logic       do_evict;
    logic       do_store;
    logic       do_delete;
    logic       emit_final;
    logic [1:0] final_status;
  } bbce_cmd_t;

  typedef struct packed {
    logic is_delete;
    logic too_big;
    logic need_room;
    logic scan_done;
    logic old_found;
    logic free_found;
    logic match_found;
    logic out_free;
  } bbce_sts_t;

endpackage

FILE: sv/bbce_ram.sv
// Generic simple dual port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/bbce_ctrl.sv
// Controller for the byte budget cache evictor: sequences scan, eviction and
// final status. Depends on bbce_pkg.
`timescale 1ns / 1ps

module bbce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  output logic               in_ready,
  input  bbce_pkg::bbce_sts_t sts,
  output bbce_pkg::bbce_cmd_t cmd
);
  import bbce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_EVICT,
    S_FINAL
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] fin_status_r, fin_status_nxt;
  logic       fin_store_r, fin_store_nxt;
  logic       fin_del_r, fin_del_nxt;

  always_comb begin
    state_nxt      = state_r;
    fin_status_nxt = fin_status_r;
    fin_store_nxt  = fin_store_r;
    fin_del_nxt    = fin_del_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_delete && sts.too_big) begin
          fin_status_nxt = ST_TOO_BIG;
          fin_store_nxt  = 1'b0;
          fin_del_nxt    = 1'b0;
          state_nxt      = S_FINAL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_delete) begin
          fin_status_nxt = sts.match_found ? ST_OK : ST_NOMATCH;
          fin_store_nxt  = 1'b0;
          fin_del_nxt    = sts.match_found;
          state_nxt      = S_FINAL;
        end else if ((sts.need_room || !sts.free_found) && sts.old_found) begin
          state_nxt = S_EVICT;
        end else begin
          fin_status_nxt = ST_OK;
          fin_store_nxt  = sts.free_found;
          fin_del_nxt    = 1'b0;
          state_nxt      = S_FINAL;
        end
      end
      S_EVICT: begin
        // eviction result goes out and the table is rescanned
        if (sts.out_free) begin
          state_nxt = S_SCAN;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fin_status_r <= ST_OK;
      fin_store_r  <= 1'b0;
      fin_del_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fin_status_r <= fin_status_nxt;
      fin_store_r  <= fin_store_nxt;
      fin_del_r    <= fin_del_nxt;
    end
  end

  always_comb begin
    in_ready         = (state_r == S_IDLE);
    cmd.capture      = (state_r == S_IDLE) && in_accept;
    cmd.scan_start   = ((state_r == S_CHECK) && !(!sts.is_delete && sts.too_big)) ||
                       ((state_r == S_EVICT) && sts.out_free);
    cmd.do_evict     = (state_r == S_EVICT) && sts.out_free;
    cmd.emit_final   = (state_r == S_FINAL) && sts.out_free;
    cmd.do_store     = cmd.emit_final && fin_store_r;
    cmd.do_delete    = cmd.emit_final && fin_del_r;
    cmd.final_status = fin_status_r;
  end

endmodule

FILE: sv/bbce_dp.sv
// Datapath for the byte budget cache evictor: slot table, scan unit, totals,
// budget register and output register. Depends on bbce_pkg and bbce_ram.
`timescale 1ns / 1ps

module bbce_dp #(
  parameter int SLOTS = bbce_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbce_pkg::bbce_cmd_t           cmd,
  output bbce_pkg::bbce_sts_t           sts,
  input  logic                          in_command,
  input  logic [bbce_pkg::KEY_W-1:0]    in_key,
  input  logic [bbce_pkg::BYTES_W-1:0]  in_bytes,
  input  logic                          cfg_valid,
  input  logic [bbce_pkg::BYTES_W-1:0]  cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_is_eviction,
  output logic [1:0]                    out_status,
  output logic [bbce_pkg::KEY_W-1:0]    out_key,
  output logic [bbce_pkg::BYTES_W-1:0]  out_bytes,
  output logic [bbce_pkg::BYTES_W-1:0]  out_total,
  output logic                          out_last
);
  import bbce_pkg::*;
  `include "byte_budget_cache_evictor_defines.svh"

  localparam int IW = $clog2(SLOTS);

  // captured transaction and block state
  logic                 cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [BYTES_W-1:0]   budget_r;
  logic [BYTES_W-1:0]   total_r, total_nxt;
  logic [STAMP_W-1:0]   counter_r;
  logic [SLOTS-1:0]     slot_valid_r, slot_valid_nxt;

  // scan unit
  logic                 issue_r;
  logic [IW-1:0]        addr_r;
  logic                 s1_vld_r;
  logic [IW-1:0]        s1_idx_r;
  logic                 s1_last_r;
  logic                 scan_done_r;
  logic                 old_found_r, free_found_r, match_found_r;
  logic [IW-1:0]        old_idx_r, free_idx_r, match_idx_r;
  logic [STAMP_W-1:0]   old_age_r, match_age_r;
  logic [KEY_W-1:0]     old_key_r;
  logic [BYTES_W-1:0]   old_bytes_r;

  // output register
  logic                 out_valid_r;
  logic                 out_is_ev_r;
  logic [1:0]           out_status_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [BYTES_W-1:0]   out_bytes_r;
  logic [BYTES_W-1:0]   out_total_r;
  logic                 out_last_r;

  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;
  logic [ENTRY_W-1:0]   rd_data;
  logic [KEY_W-1:0]     rd_key;
  logic [BYTES_W-1:0]   rd_bytes;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [STAMP_W-1:0]   age;
  logic                 ent_valid;
  logic                 ent_match;
  logic                 load_out;

  assign wr_en   = cmd.do_store;
  assign wr_data = {key_r, bytes_r, counter_r};

  bbce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_data),
    .rd_en   (issue_r),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign {rd_key, rd_bytes, rd_stamp} = rd_data;
  assign age       = counter_r - rd_stamp;
  assign ent_valid = slot_valid_r[s1_idx_r];
  assign ent_match = ent_valid && (rd_key == key_r) && (rd_bytes == bytes_r);

  always_comb begin
    total_nxt      = total_r;
    slot_valid_nxt = slot_valid_r;
    if (cmd.do_evict) begin
      total_nxt               = total_r - old_bytes_r;
      slot_valid_nxt[old_idx_r] = 1'b0;
    end else if (cmd.do_store) begin
      total_nxt                = total_r + bytes_r;
      slot_valid_nxt[free_idx_r] = 1'b1;
    end else if (cmd.do_delete) begin
      total_nxt                 = total_r - bytes_r;
      slot_valid_nxt[match_idx_r] = 1'b0;
    end
  end

  assign load_out = cmd.do_evict || cmd.emit_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r     <= BUDGET_RESET;
      total_r      <= '0;
      counter_r    <= '0;
      slot_valid_r <= '0;
      issue_r      <= 1'b0;
      s1_vld_r     <= 1'b0;
      scan_done_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        budget_r <= cfg_data;
      end
      total_r      <= total_nxt;
      slot_valid_r <= slot_valid_nxt;
      if (cmd.do_store) begin
        counter_r <= counter_r + 1'b1;
      end
      if (cmd.scan_start) begin
        issue_r <= 1'b1;
      end else if (issue_r && (addr_r == IW'(SLOTS - 1))) begin
        issue_r <= 1'b0;
      end
      s1_vld_r    <= issue_r;
      scan_done_r <= s1_vld_r && s1_last_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      key_r   <= in_key;
      bytes_r <= in_bytes;
    end
    if (cmd.scan_start) begin
      addr_r <= '0;
    end else if (issue_r) begin
      addr_r <= addr_r + 1'b1;
    end
    s1_idx_r  <= addr_r;
    s1_last_r <= (addr_r == IW'(SLOTS - 1));
    if (cmd.scan_start) begin
      old_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
    end else if (s1_vld_r) begin
      // oldest valid entry, ties to the lower slot
      if (ent_valid && (!old_found_r || age > old_age_r)) begin
        old_found_r <= 1'b1;
        old_idx_r   <= s1_idx_r;
        old_age_r   <= age;
        old_key_r   <= rd_key;
        old_bytes_r <= rd_bytes;
      end
      if (!ent_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= s1_idx_r;
      end
      // newest matching entry, ties to the lower slot
      if (ent_match && (!match_found_r || age < match_age_r)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= s1_idx_r;
        match_age_r   <= age;
      end
    end
    if (cmd.do_evict) begin
      out_is_ev_r  <= 1'b1;
      out_status_r <= ST_OK;
      out_key_r    <= old_key_r;
      out_bytes_r  <= old_bytes_r;
      out_total_r  <= total_nxt;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_final) begin
      out_is_ev_r  <= 1'b0;
      out_status_r <= cmd.final_status;
      out_key_r    <= '0;
      out_bytes_r  <= '0;
      out_total_r  <= total_nxt;
      out_last_r   <= 1'b1;
    end
  end

  always_comb begin
    sts.is_delete   = (cmd_r == CMD_DELETE);
    sts.too_big     = (bytes_r >= budget_r);
    sts.need_room   = ({1'b0, total_r} + {1'b0, bytes_r}) > {1'b0, budget_r};
    sts.scan_done   = scan_done_r;
    sts.old_found   = old_found_r;
    sts.free_found  = free_found_r;
    sts.match_found = match_found_r;
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_is_eviction = out_is_ev_r;
  assign out_status      = out_status_r;
  assign out_key         = out_key_r;
  assign out_bytes       = out_bytes_r;
  assign out_total       = out_total_r;
  assign out_last        = out_last_r;

  `BBCE_ASSERT_IMPL(a_load_needs_room, clk, rst_n, load_out, !out_valid_r || out_ready)
  `BBCE_ASSERT_IMPL(a_evict_has_victim, clk, rst_n, cmd.do_evict, old_found_r)
  `BBCE_ASSERT_IMPL(a_store_has_slot, clk, rst_n, cmd.do_store,
                    free_found_r && !slot_valid_r[free_idx_r])
  `BBCE_ASSERT_IMPL(a_no_write_in_scan, clk, rst_n, issue_r || s1_vld_r, !wr_en)
  `BBCE_ASSERT_NEXT(a_done_after_last, clk, rst_n, s1_vld_r && s1_last_r, scan_done_r)

endmodule

FILE: sv/byte_budget_cache_evictor.sv
// Top level of the byte budget cache evictor: controller plus datapath.
// Depends on bbce_pkg, bbce_ctrl, bbce_dp and bbce_ram.
//
//  channel | direction | payload
//  in_     | slave     | tuser: command; tdata: object_key, object_bytes
//  out_    | master    | tuser: is_eviction; tdata: status, key, bytes, total; tlast
//  cfg_    | slave     | data: byte_budget
//
// Each table scan reads every slot through the slot RAM read port.
// Delete or insert without eviction: one scan; every eviction adds another
// scan. A rejected insert finishes without a scan.
// Reset: synchronous, clears all slots and totals, budget returns to 1000.
// A stalled output holds the block at its next result; input is taken only
// when the previous transaction has handed over its final status.
`timescale 1ns / 1ps

module byte_budget_cache_evictor #(
  parameter int SLOTS = bbce_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // [63:0] object_key, [95:64] object_bytes
  input  logic [0:0]    in_tuser,   // [0] command
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // [1:0] status, [65:2] evicted_key,
                                    // [97:66] evicted_bytes, [129:98] total_after
  output logic [0:0]    out_tuser,  // [0] is_eviction
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import bbce_pkg::*;

  bbce_cmd_t cmd;
  bbce_sts_t sts;

  logic               in_accept;
  logic               out_is_eviction;
  logic [1:0]         out_status;
  logic [KEY_W-1:0]   out_key;
  logic [BYTES_W-1:0] out_bytes;
  logic [BYTES_W-1:0] out_total;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  bbce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbce_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_tuser[0]),
    .in_key          (in_tdata[63:0]),
    .in_bytes        (in_tdata[95:64]),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_is_eviction (out_is_eviction),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_bytes       (out_bytes),
    .out_total       (out_total),
    .out_last        (out_tlast)
  );

  assign out_tdata = {6'd0, out_total, out_bytes, out_key, out_status};
  assign out_tuser = out_is_eviction;

endmodule
